/* hw/rtl/varint_sign_magnitude_encoder_macros.svh */
// Assertion macros shared by the varint encoder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef VARINT_SIGN_MAGNITUDE_ENCODER_MACROS_SVH
`define VARINT_SIGN_MAGNITUDE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define VSME_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VSME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vsme_pkg.sv */
// Shared types and constants for the varint sign/magnitude encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package vsme_pkg;

    localparam int VSME_VALUE_W = 64;
    localparam int VSME_OP_W    = 3;
    localparam int VSME_BYTE_W  = 8;
    localparam int VSME_GROUP_W = 7;

    // Default depth of the queue between front and back end
    localparam int VSME_QUEUE_DEPTH = 2;

    // Opcodes
    localparam logic [VSME_OP_W-1:0] VSME_OP_RAW = 3'd0;
    localparam logic [VSME_OP_W-1:0] VSME_OP_U16 = 3'd1;
    localparam logic [VSME_OP_W-1:0] VSME_OP_U32 = 3'd2;
    localparam logic [VSME_OP_W-1:0] VSME_OP_U64 = 3'd3;
    localparam logic [VSME_OP_W-1:0] VSME_OP_S32 = 3'd4;
    localparam logic [VSME_OP_W-1:0] VSME_OP_S64 = 3'd5;

    // Continuation flag and low-group mask of an encoded byte
    localparam logic [VSME_BYTE_W-1:0] VSME_MORE_FLAG  = 8'd128;
    localparam logic [VSME_BYTE_W-1:0] VSME_SEVEN_MASK = 8'd127;

    // One classified item: raw bytes go out once, codes are split in groups
    typedef struct packed {
        logic                    raw;
        logic [VSME_VALUE_W-1:0] code;
    } vsme_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/varint_sign_magnitude_encoder.sv */
// Varint encoder with signed sign/magnitude folding, top level.
// Depends on vsme_pkg, vsme_front, vsme_queue and vsme_back.
//
// Each input transaction carries an opcode in s_tuser and a 64-bit operand
// in s_tdata; the block returns the operand's LEB128-style encoding as one
// byte per output transaction, bit 7 set on every byte but the final one,
// which is flagged by m_tlast. Raw bytes pass as one byte; signed kinds are
// folded to (magnitude << 1) | sign at the operand width; opcodes 6 and 7
// are accepted and produce nothing. An item has 1 to 10 bytes; the back-end
// serializer emits one byte per cycle unless m_tready stalls it, and the front
// end classifies one item per cycle while the queue is not full, into a
// QueueDepth-entry queue, so input is accepted while earlier items are still
// being sent. Each item passes from the queue to the serializer's command register.
`default_nettype none

module varint_sign_magnitude_encoder
    import vsme_pkg::*;
#(
    parameter int QueueDepth = VSME_QUEUE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [VSME_VALUE_W-1:0] s_tdata,  // [63:0] value
    input  wire logic [VSME_OP_W-1:0]    s_tuser,  // [2:0] opcode
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [VSME_BYTE_W-1:0]       m_tdata,  // [7:0] out_byte
    output logic                         m_tlast
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_not_empty;
    vsme_cmd_t q_in;
    vsme_cmd_t q_out;

    vsme_front u_front (
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    vsme_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    vsme_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/vsme_front.sv */
// Front end: accepts input transactions and folds each known opcode into an unsigned code.
// Depends on vsme_pkg; feeds vsme_queue.
`default_nettype none

module vsme_front
    import vsme_pkg::*;
(
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [VSME_VALUE_W-1:0] s_tdata,  // [63:0] value
    input  wire logic [VSME_OP_W-1:0]    s_tuser,  // [2:0] opcode
    input  wire logic                    q_full,
    output logic                         q_push,
    output vsme_cmd_t                    q_data
);

    logic                    keep;
    logic                    sign32;
    logic                    sign64;
    logic [31:0]             mag32;
    logic [VSME_VALUE_W-1:0] mag64;

    // Magnitudes of the signed kinds
    assign sign32 = s_tdata[31];
    assign sign64 = s_tdata[VSME_VALUE_W-1];
    assign mag32  = sign32 ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
    assign mag64  = sign64 ? ({VSME_VALUE_W{1'b0}} - s_tdata) : s_tdata;

    // Classify by opcode; unknown opcodes are taken and dropped
    always_comb begin
        keep        = 1'b1;
        q_data.raw  = 1'b0;
        q_data.code = '0;
        case (s_tuser)
            VSME_OP_RAW: begin
                q_data.raw  = 1'b1;
                q_data.code = {56'd0, s_tdata[7:0]};
            end
            VSME_OP_U16: q_data.code = {48'd0, s_tdata[15:0]};
            VSME_OP_U32: q_data.code = {32'd0, s_tdata[31:0]};
            VSME_OP_U64: q_data.code = s_tdata;
            VSME_OP_S32: q_data.code = {32'd0, mag32[30:0], sign32};
            VSME_OP_S64: q_data.code = {mag64[VSME_VALUE_W-2:0], sign64};
            default: keep = 1'b0;
        endcase
    end

    assign s_tready = aresetn & ~q_full;
    assign q_push   = s_tvalid & s_tready & keep;

endmodule

`default_nettype wire

/* hw/rtl/vsme_queue.sv */
// Short FIFO of classified commands between the front and back ends.
// Depends on vsme_pkg for the command type.
`default_nettype none

module vsme_queue
    import vsme_pkg::*;
#(
    parameter int Depth = VSME_QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  vsme_cmd_t      push_data,
    output logic           full,
    input  wire logic      pop,
    output vsme_cmd_t      pop_data,
    output logic           not_empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    vsme_cmd_t         entry_reg [Depth];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign full      = (count_reg == CW'(Depth));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/vsme_back.sv */
// Back end: sends each queued code, raw bytes whole and others in 7-bit groups,
// one byte a cycle unless stalled. Depends on vsme_pkg and the assertion macros.
`default_nettype none
`include "varint_sign_magnitude_encoder_macros.svh"

module vsme_back
    import vsme_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  vsme_cmd_t                   q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [VSME_BYTE_W-1:0]      m_tdata,  // [7:0] out_byte
    output logic                        m_tlast
);

    logic                   busy_reg;
    logic                   busy_next;
    vsme_cmd_t              cmd_reg;
    vsme_cmd_t              cmd_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [VSME_BYTE_W-1:0] m_data_reg;
    logic [VSME_BYTE_W-1:0] m_data_next;
    logic                   m_last_reg;
    logic                   m_last_next;

    logic                   out_free;
    logic                   advance;
    logic                   cur_last;
    logic [VSME_BYTE_W-1:0] cur_byte;

    // Current byte: final when raw or nothing above the low group remains
    assign cur_last = cmd_reg.raw | (cmd_reg.code[VSME_VALUE_W-1:VSME_GROUP_W] == '0);
    assign cur_byte = cur_last ? cmd_reg.code[VSME_BYTE_W-1:0]
                               : ((cmd_reg.code[VSME_BYTE_W-1:0] & VSME_SEVEN_MASK)
                                  | VSME_MORE_FLAG);

    assign out_free = ~m_valid_reg | m_tready;
    assign advance  = busy_reg & out_free;
    assign q_pop    = q_valid & (~busy_reg | (advance & cur_last));

    // Serializer and output register
    always_comb begin
        busy_next    = busy_reg;
        cmd_next     = cmd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = cur_byte;
            m_last_next  = cur_last;
            if (cur_last) begin
                busy_next = 1'b0;
            end else begin
                cmd_next.code = cmd_reg.code >> VSME_GROUP_W;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            busy_next = 1'b1;
            cmd_next  = q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    `VSME_ASSERT_NEXT(a_more_keeps_busy, aclk, aresetn, advance && !cur_last, busy_reg, "serializer stopped before the final byte")
    `VSME_ASSERT_IMPL(a_more_flag_set, aclk, aresetn, m_valid_reg && !m_last_reg, m_data_reg[VSME_BYTE_W-1], "non-final byte lacks continuation flag")
    `VSME_ASSERT_NEXT(a_pop_loads_busy, aclk, aresetn, q_pop, busy_reg, "popped command was not loaded")
    `VSME_ASSERT_IMPL(a_pop_only_free, aclk, aresetn, q_pop && busy_reg, advance && cur_last, "pop while current code still has bytes")

endmodule

`default_nettype wire

/* dv/tb_varint_sign_magnitude_encoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for varint_sign_magnitude_encoder: directed corners,
// random bursts, receiver hold-off and drain pauses. Depends on vsme_pkg.
module tb_varint_sign_magnitude_encoder;
    import vsme_pkg::*;

    // Opcodes the block accepts and drops
    localparam logic [VSME_OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [VSME_OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned MAX_REPORTS    = 200;

    typedef struct {
        logic [VSME_BYTE_W-1:0] enc_byte;
        logic                   last;
    } varint_byte_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [VSME_VALUE_W-1:0] s_tdata;   // [63:0] value
    logic [VSME_OP_W-1:0]    s_tuser;   // [2:0] opcode
    logic                    m_tvalid;
    logic                    m_tready;
    logic [VSME_BYTE_W-1:0]  m_tdata;   // [7:0] out_byte
    logic                    m_tlast;

    varint_byte_t pending_bytes[$];
    int unsigned  error_count = 0;
    int unsigned  stall_cycles = 0;
    logic         rx_hold_req = 1'b0;

    varint_sign_magnitude_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Encoding predictor
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [VSME_BYTE_W-1:0] b, input logic is_last);
        varint_byte_t entry;
        entry.enc_byte = b;
        entry.last     = is_last;
        pending_bytes.push_back(entry);
    endfunction

    // Folds the operand to its unsigned code and queues its byte groups; raw bytes go whole
    function automatic void predict_encoding(input logic [VSME_OP_W-1:0] op,
                                             input logic [VSME_VALUE_W-1:0] val);
        logic [VSME_VALUE_W-1:0] code;
        logic [VSME_VALUE_W-1:0] mag;
        logic [31:0]             v32;
        logic [31:0]             mag32;
        logic                    has_code;
        has_code = 1'b1;
        code     = '0;
        case (op)
            VSME_OP_RAW: begin
                push_byte(val[7:0], 1'b1);
                has_code = 1'b0;
            end
            VSME_OP_U16: code = {48'd0, val[15:0]};
            VSME_OP_U32: code = {32'd0, val[31:0]};
            VSME_OP_U64: code = val;
            VSME_OP_S32: begin
                v32   = val[31:0];
                mag32 = v32[31] ? (32'd0 - v32) : v32;
                code  = {32'd0, mag32[30:0], v32[31]};
            end
            VSME_OP_S64: begin
                mag  = val[63] ? (64'd0 - val) : val;
                code = {mag[62:0], val[63]};
            end
            default: has_code = 1'b0;
        endcase
        if (has_code) begin
            while (code > {56'd0, VSME_SEVEN_MASK}) begin
                push_byte(VSME_MORE_FLAG | (code[7:0] & VSME_SEVEN_MASK), 1'b0);
                code = code >> VSME_GROUP_W;
            end
            push_byte(code[7:0], 1'b1);
        end
    endfunction

    function automatic void log_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predicts on input transactions, checks output ones
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        varint_byte_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_encoding(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (pending_bytes.size() == 0) begin
                    log_failure($sformatf("unexpected byte: expected none, got %02h last %b",
                                          m_tdata, m_tlast));
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_tdata !== want.enc_byte)
                        log_failure($sformatf("out_byte: expected %02h, got %02h",
                                              want.enc_byte, m_tdata));
                    if (m_tlast !== want.last)
                        log_failure($sformatf("last: expected %b, got %b",
                                              want.last, m_tlast));
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver pacing: segments of random stall density, plus long hold
    // ------------------------------------------------------------------
    initial begin : rx_pacing
        int unsigned seg_len;
        int unsigned stall_pct;
        m_tready = 1'b0;
        forever begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                2:       stall_pct = 70;
                default: stall_pct = 90;
            endcase
            repeat (seg_len) begin
                @(posedge aclk);
                if (rx_hold_req) begin
                    m_tready <= 1'b0;
                    repeat (RX_HOLD_CYCLES) @(posedge aclk);
                    rx_hold_req = 1'b0;
                end
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------
    // Offers one transaction and returns on the edge that takes it; valid
    // stays high so a following send keeps the stream back to back
    task automatic send_item(input logic [VSME_OP_W-1:0] op,
                             input logic [VSME_VALUE_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_bytes.size() != 0);
    endtask

    function automatic logic [VSME_OP_W-1:0] rand_opcode();
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) return OP_UNUSED_6;
        if (pick == 1) return OP_UNUSED_7;
        case (pick % 6)
            0:       return VSME_OP_RAW;
            1:       return VSME_OP_U16;
            2:       return VSME_OP_U32;
            3:       return VSME_OP_U64;
            4:       return VSME_OP_S32;
            default: return VSME_OP_S64;
        endcase
    endfunction

    // Mix of full-width, short, group-boundary and negative operands
    function automatic logic [VSME_VALUE_W-1:0] rand_operand();
        logic [VSME_VALUE_W-1:0] v;
        int unsigned             sh;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: ;
            1: v = v >> $urandom_range(0, 63);
            2: v = 64'($urandom_range(0, 300));
            3: begin
                sh = VSME_GROUP_W * $urandom_range(1, 9);
                v  = (64'd1 << sh) - 64'($urandom_range(0, 1));
            end
            default: v = ~(v >> $urandom_range(0, 63));
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // raw byte, upper bits ignored
        send_item(VSME_OP_RAW, 64'h0);
        send_item(VSME_OP_RAW, 64'hDEAD_BEEF_CAFE_12FF);
        // u16: zero, one-byte max, first two-byte code, max with junk above
        send_item(VSME_OP_U16, 64'd0);
        send_item(VSME_OP_U16, 64'd127);
        send_item(VSME_OP_U16, 64'd128);
        send_item(VSME_OP_U16, 64'hFFFF_FFFF_FFFF_FFFF);
        // u32
        send_item(VSME_OP_U32, 64'h0000_0000_FFFF_FFFF);
        send_item(VSME_OP_U32, 64'h5A5A_5A5A_0000_0080);
        // u64: zero, all ones (ten bytes), top bit only
        send_item(VSME_OP_U64, 64'd0);
        send_item(VSME_OP_U64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(VSME_OP_U64, 64'h8000_0000_0000_0000);
        // signed 32: zero, minus one, most negative, most positive, junk above
        send_item(VSME_OP_S32, 64'd0);
        send_item(VSME_OP_S32, 64'h0000_0000_FFFF_FFFF);
        send_item(VSME_OP_S32, 64'h0000_0000_8000_0000);
        send_item(VSME_OP_S32, 64'h0000_0000_7FFF_FFFF);
        send_item(VSME_OP_S32, 64'hABCD_0000_0000_0005);
        // signed 64
        send_item(VSME_OP_S64, 64'd0);
        send_item(VSME_OP_S64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(VSME_OP_S64, 64'h8000_0000_0000_0000);
        send_item(VSME_OP_S64, 64'h7FFF_FFFF_FFFF_FFFF);
        // unused opcodes produce nothing
        send_item(OP_UNUSED_6, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_UNUSED_7, 64'h0123_4567_89AB_CDEF);
        send_item(VSME_OP_RAW, 64'h0000_0000_0000_0042);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned             sent;
        int unsigned             burst;
        logic [VSME_OP_W-1:0]    op;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                op = rand_opcode();
                send_item(op, rand_operand());
                if (op != OP_UNUSED_6 && op != OP_UNUSED_7) sent++;
            end
            case ($urandom_range(0, 9))
                0:       wait_drain();
                1, 2, 3: ;  // next burst follows back to back
                default: pause_sender($urandom_range(1, 12));
            endcase
        end
        wait_drain();
    endtask

    // Receiver holds off while long encodings keep coming, so input stalls
    task automatic test_receiver_hold();
        rx_hold_req = 1'b1;
        repeat (20) send_item(VSME_OP_U64, {1'b1, 63'($urandom)} | {$urandom, $urandom});
        wait_drain();
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_drain_pauses();
        repeat (3) begin
            repeat (6) send_item(rand_opcode(), rand_operand());
            wait_drain();
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = VSME_OP_RAW;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_receiver_hold();
        test_random_traffic(260);
        test_drain_pauses();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_bytes.size() != 0)
            log_failure($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/vsme_pkg.sv
hw/rtl/vsme_front.sv
hw/rtl/vsme_queue.sv
hw/rtl/vsme_back.sv
hw/rtl/varint_sign_magnitude_encoder.sv
dv/tb_varint_sign_magnitude_encoder.sv
